// ===== design/rdme_pkg.sv =====
// ----------------------------------------------------------------------------
// Reference diff mutation extractor package
// Shared widths, codes, record type and queue control type.
// ----------------------------------------------------------------------------
package rdme_pkg;

	localparam longint MAX_SEQ_LEN = 1048576;

	localparam int CHAR_W = 8;
	localparam int MODE_W = 3;
	localparam int CODE_W = 6;
	localparam int POS_W  = 20;
	localparam int LEN_W  = 21;

	localparam longint POS_SPAN = longint'(1) << POS_W;
	localparam longint LEN_MAX  = (longint'(1) << LEN_W) - 1;

	localparam logic [POS_W-1:0] POS_LAST =
		(MAX_SEQ_LEN < POS_SPAN) ? POS_W'(MAX_SEQ_LEN - 1) : '1;
	localparam logic [LEN_W-1:0] RUN_CAP =
		(MAX_SEQ_LEN < LEN_MAX) ? LEN_W'(MAX_SEQ_LEN) : '1;

	localparam logic [CODE_W-1:0] CODE_NONE     = 6'd0;
	localparam logic [CODE_W-1:0] CODE_UNKNOWN  = 6'd32;
	localparam logic [CODE_W-1:0] CODE_DELETION = 6'd33;

	localparam logic [CHAR_W-1:0] CHAR_GAP = 8'h2D;
	localparam logic [CHAR_W-1:0] CHAR_N   = 8'h4E;

	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [MODE_W-1:0] {
		MODE_DNA     = 3'd0,
		MODE_PROTEIN = 3'd1,
		MODE_BINARY  = 3'd2,
		MODE_MORPH   = 3'd3,
		MODE_UNKNOWN = 3'd4
	} alpha_mode_t;

	typedef enum logic [1:0] {
		RUN_NONE     = 2'd0,
		RUN_UNKNOWN  = 2'd1,
		RUN_DELETION = 2'd2
	} run_mode_t;

	typedef struct packed {
		logic [CODE_W-1:0] code;
		logic [POS_W-1:0]  start;
		logic [LEN_W-1:0]  len;
		logic              bad;
		logic              last;
	} rec_t;

	typedef struct packed {
		logic first;
		logic second;
	} queue_push_t;

endpackage

// ===== design/rdme_decode.sv =====
// ----------------------------------------------------------------------------
// Character decoder
// Converts one sequence character to a state code for the alphabet mode.
// ----------------------------------------------------------------------------
module rdme_decode (
	input  logic [rdme_pkg::CHAR_W-1:0] char_in,
	input  logic [rdme_pkg::MODE_W-1:0] mode,
	output logic [rdme_pkg::CODE_W-1:0] code,
	output logic                        bad
);
	import rdme_pkg::*;

	always_comb begin
		code = CODE_NONE;
		bad  = 1'b0;
		if (char_in == CHAR_GAP) begin
			code = CODE_DELETION;
		end else if (char_in == "?" || char_in == "." || char_in == "~") begin
			code = CODE_UNKNOWN;
		end else begin
			bad = 1'b1;
			case (mode)
				MODE_DNA: begin
					bad = 1'b0;
					case (char_in) inside
						"A":           code = 6'd0;
						"C":           code = 6'd1;
						"G":           code = 6'd2;
						"T", "U":      code = 6'd3;
						"R":           code = 6'd8;
						"Y":           code = 6'd13;
						"O", "N", "X": code = CODE_UNKNOWN;
						"W":           code = 6'd12;
						"S":           code = 6'd9;
						"M":           code = 6'd6;
						"K":           code = 6'd15;
						"B":           code = 6'd17;
						"H":           code = 6'd14;
						"D":           code = 6'd16;
						"V":           code = 6'd10;
						default:       bad  = 1'b1;
					endcase
				end
				MODE_PROTEIN: begin
					bad = 1'b0;
					case (char_in) inside
						"A":                code = 6'd0;
						"R":                code = 6'd1;
						"N":                code = 6'd2;
						"D":                code = 6'd3;
						"C":                code = 6'd4;
						"Q":                code = 6'd5;
						"E":                code = 6'd6;
						"G":                code = 6'd7;
						"H":                code = 6'd8;
						"I":                code = 6'd9;
						"L":                code = 6'd10;
						"K":                code = 6'd11;
						"M":                code = 6'd12;
						"F":                code = 6'd13;
						"P":                code = 6'd14;
						"S":                code = 6'd15;
						"T":                code = 6'd16;
						"W":                code = 6'd17;
						"Y":                code = 6'd18;
						"V":                code = 6'd19;
						"B":                code = 6'd20;
						"Z":                code = 6'd21;
						"J":                code = 6'd22;
						"*", "U", "O", "X": code = CODE_UNKNOWN;
						default:            bad  = 1'b1;
					endcase
				end
				MODE_BINARY: begin
					bad = 1'b0;
					case (char_in) inside
						"0":     code = 6'd0;
						"1":     code = 6'd1;
						default: bad  = 1'b1;
					endcase
				end
				MODE_MORPH: begin
					bad = 1'b0;
					case (char_in) inside
						["0":"9"]: code = CODE_W'(char_in - "0");
						["A":"V"]: code = CODE_W'(char_in - "A" + 8'd10);
						default:   bad  = 1'b1;
					endcase
				end
				default: bad = 1'b1;
			endcase
		end
	end

endmodule

// ===== design/rdme_queue.sv =====
// ----------------------------------------------------------------------------
// Record queue
// Small queue that takes up to two records per cycle and gives one.
// ----------------------------------------------------------------------------
module rdme_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  rdme_pkg::queue_push_t push,
	input  rdme_pkg::rec_t        rec_first,
	input  rdme_pkg::rec_t        rec_second,
	input  logic                  pop,
	output rdme_pkg::rec_t        head,
	output logic                  not_empty,
	output logic                  room_two
);
	import rdme_pkg::*;

	rec_t                mem_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] wr_ptr_q;
	logic [QUEUE_AW-1:0] rd_ptr_q;
	logic [QUEUE_CW-1:0] count_q;
	logic [QUEUE_AW-1:0] wr_ptr_next;
	logic                do_pop;

	assign wr_ptr_next = wr_ptr_q + QUEUE_AW'(1);
	assign not_empty   = (count_q != '0);
	assign room_two    = (count_q <= QUEUE_CW'(QUEUE_DEPTH - 2));
	assign do_pop      = pop && not_empty;
	assign head        = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push.first) begin
			mem_q[wr_ptr_q] <= rec_first;
		end
		if (push.second) begin
			mem_q[wr_ptr_next] <= rec_second;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + QUEUE_AW'(push.first) + QUEUE_AW'(push.second);
			rd_ptr_q <= rd_ptr_q + QUEUE_AW'(do_pop);
			count_q  <= count_q + QUEUE_CW'(push.first) + QUEUE_CW'(push.second)
				- QUEUE_CW'(do_pop);
		end
	end

endmodule

// ===== design/reference_diff_mutation_extractor_top.sv =====
// ----------------------------------------------------------------------------
// Reference diff mutation extractor
// Compares aligned sequence characters with the reference and emits
// mutation records, merging runs of unknown and gap characters.
// ----------------------------------------------------------------------------
// The input channel carries one sequence character, the reference character
// and an end-of-sequence flag per transaction. The output channel carries
// one mutation record per transaction; an input transaction causes zero, one
// or two records, and last_of_item marks the final one of them.
// An accepted transaction is held in an input register, is compared and
// decoded there, and its records enter a four-entry queue when it has room
// for two records; the first record is then offered at the queue head.
// A new input transaction is taken every cycle as long as the queue has room
// for two records; the output side drains one record per cycle while
// out_stall is low, so the sustained rate is one item per cycle for items
// with at most one record. When the receiver stalls, the queue fills and
// in_stall rises; the head record holds until it is taken. Reset clears
// the run state, the position counter, the queue and the alphabet mode
// (DNA). cfg_write_en writes the alphabet mode at the edge where it is high.
// ----------------------------------------------------------------------------
module reference_diff_mutation_extractor_top (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_write_en,
	input  logic [rdme_pkg::MODE_W-1:0] cfg_write_data,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [rdme_pkg::CHAR_W-1:0] seq_char,
	input  logic [rdme_pkg::CHAR_W-1:0] ref_char,
	input  logic                        end_of_sequence,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [rdme_pkg::CODE_W-1:0] state_code,
	output logic [rdme_pkg::POS_W-1:0]  start_position,
	output logic [rdme_pkg::LEN_W-1:0]  run_length,
	output logic                        bad_char,
	output logic                        last_of_item
);
	import rdme_pkg::*;

	logic [MODE_W-1:0] alphabet_mode_q;
	logic              valid_s1;
	logic [CHAR_W-1:0] seq_s1;
	logic [CHAR_W-1:0] ref_s1;
	logic              eos_s1;

	run_mode_t         run_mode_q;
	logic [LEN_W-1:0]  run_count_q;
	logic [POS_W-1:0]  position_q;

	logic              in_accept;
	logic              advance;
	logic              room_two;
	logic              not_empty;
	rec_t              head;

	logic [CODE_W-1:0] dec_code;
	logic              dec_bad;

	run_mode_t         mode_next;
	logic [LEN_W-1:0]  count_next;
	logic [POS_W-1:0]  pos_next;
	queue_push_t       push;
	rec_t              rec_first;
	rec_t              rec_second;

	assign in_stall  = valid_s1 && !room_two;
	assign in_accept = in_valid && !in_stall;
	assign advance   = valid_s1 && room_two;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alphabet_mode_q <= MODE_DNA;
		end else if (cfg_write_en) begin
			alphabet_mode_q <= cfg_write_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			seq_s1 <= seq_char;
			ref_s1 <= ref_char;
			eos_s1 <= end_of_sequence;
		end
	end

	rdme_decode u_decode (
		.char_in (seq_s1),
		.mode    (alphabet_mode_q),
		.code    (dec_code),
		.bad     (dec_bad)
	);

	always_comb begin
		logic             mis;
		logic             is_n;
		logic             is_del;
		logic             cont;
		logic             flush;
		logic             single;
		logic             eos_flush;
		logic [POS_W-1:0] pos_plus;
		rec_t             r_flush;
		rec_t             r_single;
		rec_t             r_eos;

		mis       = (seq_s1 != ref_s1);
		is_n      = (seq_s1 == CHAR_N) && (alphabet_mode_q == MODE_DNA);
		is_del    = (seq_s1 == CHAR_GAP);
		mode_next = run_mode_q;
		count_next = run_count_q;
		flush     = 1'b0;
		single    = 1'b0;
		pos_plus  = position_q + POS_W'(1);

		r_flush.code  = (run_mode_q == RUN_UNKNOWN) ? CODE_UNKNOWN : CODE_DELETION;
		r_flush.start = position_q - run_count_q[POS_W-1:0];
		r_flush.len   = run_count_q;
		r_flush.bad   = 1'b0;
		r_flush.last  = 1'b0;

		r_single.code  = dec_code;
		r_single.start = position_q;
		r_single.len   = LEN_W'(1);
		r_single.bad   = dec_bad;
		r_single.last  = 1'b0;

		if (run_mode_q == RUN_UNKNOWN || run_mode_q == RUN_DELETION) begin
			cont = mis && ((run_mode_q == RUN_UNKNOWN) ? (seq_s1 == CHAR_N) : is_del);
			if (cont) begin
				if (run_count_q < RUN_CAP) begin
					count_next = run_count_q + LEN_W'(1);
				end
			end else begin
				flush     = 1'b1;
				mode_next = RUN_NONE;
			end
		end else begin
			cont      = 1'b0;
			mode_next = RUN_NONE;
		end

		if (!cont && mis) begin
			if (is_del) begin
				mode_next  = RUN_DELETION;
				count_next = LEN_W'(1);
			end else if (is_n) begin
				mode_next  = RUN_UNKNOWN;
				count_next = LEN_W'(1);
			end else begin
				single = 1'b1;
			end
		end

		eos_flush   = eos_s1 && (mode_next != RUN_NONE);
		r_eos.code  = (mode_next == RUN_UNKNOWN) ? CODE_UNKNOWN : CODE_DELETION;
		r_eos.start = pos_plus - count_next[POS_W-1:0];
		r_eos.len   = count_next;
		r_eos.bad   = 1'b0;
		r_eos.last  = 1'b0;

		if (eos_s1) begin
			mode_next  = RUN_NONE;
			count_next = '0;
			pos_next   = '0;
		end else begin
			pos_next = (position_q == POS_LAST) ? '0 : pos_plus;
		end

		if (flush) begin
			rec_first  = r_flush;
			rec_second = single ? r_single : r_eos;
		end else begin
			rec_first  = single ? r_single : r_eos;
			rec_second = r_eos;
		end

		push.first  = advance && (flush || single || eos_flush);
		push.second = advance && flush && (single || eos_flush);
		rec_first.last  = !(flush && (single || eos_flush));
		rec_second.last = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_mode_q  <= RUN_NONE;
			run_count_q <= '0;
			position_q  <= '0;
		end else if (advance) begin
			run_mode_q  <= mode_next;
			run_count_q <= count_next;
			position_q  <= pos_next;
		end
	end

	rdme_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.rec_first  (rec_first),
		.rec_second (rec_second),
		.pop        (!out_stall),
		.head       (head),
		.not_empty  (not_empty),
		.room_two   (room_two)
	);

	assign out_valid      = not_empty;
	assign state_code     = head.code;
	assign start_position = head.start;
	assign run_length     = head.len;
	assign bad_char       = head.bad;
	assign last_of_item   = head.last;

	a_second_needs_first: assert property (@(posedge clk) disable iff (!arst_n)
		push.second |-> push.first)
		else $error("second record pushed without a first record");

	a_eos_clears_state: assert property (@(posedge clk) disable iff (!arst_n)
		advance && eos_s1 |=> run_mode_q == RUN_NONE && run_count_q == '0 &&
			position_q == '0)
		else $error("run state not cleared after end of sequence");

	a_bad_is_single: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && bad_char |-> run_length == LEN_W'(1) && state_code == CODE_NONE)
		else $error("error record with run length other than one");

	a_open_run_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		run_mode_q != RUN_NONE |-> run_count_q != '0)
		else $error("open run with zero length");

endmodule
